/* rtl/sgf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the softened 2D gravity force pipeline.
package sgf_pkg;

   localparam int WORD_W  = 32;
   localparam int OFS_W   = 32;                  // |source - body| fits in 32 bits
   localparam int D2_W    = 66;                  // dx^2 + dy^2 + s^2, Q34.32
   localparam int ROOT_W  = 33;                  // floor(sqrt(D2)), Q17.16
   localparam int TRIAL_W = D2_W + 2;
   localparam int PROD_W  = 96;                  // G*m1*m2, Q48.48
   localparam int DEN_W   = D2_W + ROOT_W;       // D2 * R
   localparam int NUM_W   = PROD_W + OFS_W;      // G*m1*m2 * |d|
   localparam int QUO_W   = 32;
   localparam int SQ_N    = ROOT_W;              // one root bit per stage
   localparam int DIV_N   = QUO_W + 1;           // range check, then one quotient bit per stage
   localparam int PIPE_LATENCY = 3 + SQ_N + 2 + DIV_N + 1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING = 1'b1;

   localparam logic [WORD_W-1:0] GRAVITY_RESET   = 32'd65536;
   localparam logic [WORD_W-1:0] SOFTENING_RESET = 32'd0;
   localparam logic [WORD_W-1:0] POS_LIMIT       = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] NEG_LIMIT       = 32'h8000_0000;

   typedef struct packed {
      logic signed [WORD_W-1:0] body_x;
      logic signed [WORD_W-1:0] body_y;
      logic        [WORD_W-1:0] body_mass;
      logic signed [WORD_W-1:0] source_x;
      logic signed [WORD_W-1:0] source_y;
      logic        [WORD_W-1:0] source_mass;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] force_x;
      logic signed [WORD_W-1:0] force_y;
      logic                     coincident;
      logic                     clipped;
   } rsp_type;

   typedef struct packed {
      logic [D2_W-1:0]   d2;
      logic [PROD_W-1:0] prod;
      logic [OFS_W-1:0]  adx;
      logic [OFS_W-1:0]  ady;
      logic              sx;
      logic              sy;
   } sqt_tag_type;

   typedef struct packed {
      logic              valid;
      logic [ROOT_W-1:0] root;
      sqt_tag_type       tag;
   } sqt_res_type;

   typedef struct packed {
      logic sx;
      logic sy;
      logic coinc;
   } div_tag_type;

   typedef struct packed {
      logic             valid;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      logic             big_x;
      logic             big_y;
      div_tag_type      tag;
   } div_res_type;

endpackage

/* rtl/sgf_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined floored square root of the softened squared distance, one root bit per stage.
module sgf_sqrt import sgf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  sqt_tag_type in_tag,
   output sqt_res_type out_res
);

   logic [SQ_N-1:0]   vld_in, vld_ff;
   logic [D2_W-1:0]   rem_in  [SQ_N];
   logic [D2_W-1:0]   rem_ff  [SQ_N];
   logic [ROOT_W-1:0] root_in [SQ_N];
   logic [ROOT_W-1:0] root_ff [SQ_N];
   sqt_tag_type       tag_in  [SQ_N];
   sqt_tag_type       tag_ff  [SQ_N];

   // rem holds v - root^2; try setting bit b of the root
   function automatic logic [D2_W+ROOT_W-1:0] sqt_step(input logic [D2_W-1:0] rem,
                                                       input logic [ROOT_W-1:0] root,
                                                       input int b);
      logic [TRIAL_W-1:0] trial;
      trial = (TRIAL_W'(root) << (b + 1)) + (TRIAL_W'(1) << (2 * b));
      if ({2'b00, rem} >= trial) begin
         return {rem - trial[D2_W-1:0], root | (ROOT_W'(1) << b)};
      end
      return {rem, root};
   endfunction

   always_comb begin
      {rem_in[0], root_in[0]} = sqt_step(in_tag.d2, '0, ROOT_W - 1);
      vld_in[0] = in_valid;
      tag_in[0] = in_tag;
      for (int g = 1; g < SQ_N; g++) begin
         {rem_in[g], root_in[g]} = sqt_step(rem_ff[g-1], root_ff[g-1], ROOT_W - 1 - g);
         vld_in[g] = vld_ff[g-1];
         tag_in[g] = tag_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < SQ_N; g++) begin
         rem_ff[g]  <= rem_in[g];
         root_ff[g] <= root_in[g];
         tag_ff[g]  <= tag_in[g];
      end
   end

   assign out_res.valid = vld_ff[SQ_N-1];
   assign out_res.root  = root_ff[SQ_N-1];
   assign out_res.tag   = tag_ff[SQ_N-1];

endmodule

/* rtl/sgf_div.sv */
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider with quotient range check, one bit per stage.
module sgf_div import sgf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_den,
   input  logic [NUM_W-1:0] in_num_x,
   input  logic [NUM_W-1:0] in_num_y,
   input  div_tag_type      in_tag,
   output div_res_type      out_res
);

   logic [DIV_N-1:0]  vld_in, vld_ff;
   logic [DEN_W-1:0]  den_in  [DIV_N];
   logic [DEN_W-1:0]  den_ff  [DIV_N];
   logic [DEN_W-1:0]  rem_in  [DIV_N][2];
   logic [DEN_W-1:0]  rem_ff  [DIV_N][2];
   logic [QUO_W-1:0]  quo_in  [DIV_N][2];
   logic [QUO_W-1:0]  quo_ff  [DIV_N][2];
   logic [QUO_W-1:0]  nlow_in [DIV_N][2];
   logic [QUO_W-1:0]  nlow_ff [DIV_N][2];
   logic [1:0]        big_in  [DIV_N];
   logic [1:0]        big_ff  [DIV_N];
   div_tag_type       tag_in  [DIV_N];
   div_tag_type       tag_ff  [DIV_N];
   logic [NUM_W-1:0]  num_w   [2];
   logic              qbit_w  [DIV_N][2];

   // shift in one numerator bit, subtract the divisor when it fits
   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] t;
      t = {rem, nbit};
      if (t >= {1'b0, den}) begin
         return {DEN_W'(t - {1'b0, den}), 1'b1};
      end
      return {t[DEN_W-1:0], 1'b0};
   endfunction

   assign num_w[0] = in_num_x;
   assign num_w[1] = in_num_y;

   always_comb begin
      vld_in[0] = in_valid;
      den_in[0] = in_den;
      tag_in[0] = in_tag;
      for (int l = 0; l < 2; l++) begin
         // quotient of 2^32 or more always saturates
         big_in[0][l]  = DEN_W'(num_w[l][NUM_W-1:QUO_W]) >= in_den;
         rem_in[0][l]  = DEN_W'(num_w[l][NUM_W-1:QUO_W]);
         quo_in[0][l]  = '0;
         nlow_in[0][l] = num_w[l][QUO_W-1:0];
         qbit_w[0][l]  = 1'b0;
      end
      for (int g = 1; g < DIV_N; g++) begin
         vld_in[g] = vld_ff[g-1];
         den_in[g] = den_ff[g-1];
         tag_in[g] = tag_ff[g-1];
         big_in[g] = big_ff[g-1];
         for (int l = 0; l < 2; l++) begin
            {rem_in[g][l], qbit_w[g][l]} =
               div_step(rem_ff[g-1][l], nlow_ff[g-1][l][QUO_W-g], den_ff[g-1]);
            quo_in[g][l]  = {quo_ff[g-1][l][QUO_W-2:0], qbit_w[g][l]};
            nlow_in[g][l] = nlow_ff[g-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < DIV_N; g++) begin
         den_ff[g] <= den_in[g];
         tag_ff[g] <= tag_in[g];
         big_ff[g] <= big_in[g];
         for (int l = 0; l < 2; l++) begin
            rem_ff[g][l]  <= rem_in[g][l];
            quo_ff[g][l]  <= quo_in[g][l];
            nlow_ff[g][l] <= nlow_in[g][l];
         end
      end
   end

   assign out_res.valid = vld_ff[DIV_N-1];
   assign out_res.quo_x = quo_ff[DIV_N-1][0];
   assign out_res.quo_y = quo_ff[DIV_N-1][1];
   assign out_res.big_x = big_ff[DIV_N-1][0];
   assign out_res.big_y = big_ff[DIV_N-1][1];
   assign out_res.tag   = tag_ff[DIV_N-1];

endmodule

/* rtl/softened_gravity_force_2d.sv */
`timescale 1ns / 1ps
// Top level: pairwise 2D gravity force with Plummer softening, fixed point, fully pipelined.
//
//   channel   ports                        direction  transfer
//   request   start, busy, req_data        in         start high while busy low
//   response  rsp_valid, rsp_data          out        one-cycle strobe, no backpressure
//   csr       csr_we, csr_index, csr_wdata in         write when csr_we high
//
// One transaction enters every cycle; busy is always low. Each request passes through
// 3 arithmetic stages, 33 square-root stages (one root bit each), 2 product stages,
// 33 divider stages (range check plus one quotient bit each) and the output register.
// Reset clears all valid bits and loads the register defaults.
// Nothing stalls: the response side takes every result as it comes.
module softened_gravity_force_2d import sgf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [WORD_W-1:0] gravity_ff, softening_ff;

   // stage A
   logic              a_vld_ff;
   logic [OFS_W:0]    dx_w, dy_w, adx_w, ady_w;
   logic [OFS_W-1:0]  a_adx_ff, a_ady_ff;
   logic              a_sx_ff, a_sy_ff;
   logic [63:0]       a_gm1_ff, a_ss_ff;
   logic [WORD_W-1:0] a_m2_ff;

   // stage B
   logic              b_vld_ff;
   logic [63:0]       b_sqx_ff, b_sqy_ff, b_ss_ff, b_pl_ff, b_ph_ff;
   logic [OFS_W-1:0]  b_adx_ff, b_ady_ff;
   logic              b_sx_ff, b_sy_ff;

   // stage C
   logic              c_vld_ff;
   sqt_tag_type       c_tag_in, c_tag_ff;

   sqt_res_type       sq_res;

   // stages D and E
   logic              d_vld_ff;
   logic [65:0]       d_dlo_ff, d_dhi_ff;
   logic [63:0]       d_nx_ff [3];
   logic [63:0]       d_ny_ff [3];
   div_tag_type       d_tag_ff;
   logic              e_vld_ff;
   logic [DEN_W-1:0]  e_den_ff;
   logic [NUM_W-1:0]  e_nx_ff, e_ny_ff;
   div_tag_type       e_tag_ff;

   div_res_type       dv_res;
   logic              clip_x_w, clip_y_w;
   rsp_type           rsp_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= GRAVITY_RESET;
         softening_ff <= SOFTENING_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRAVITY:   gravity_ff   <= csr_wdata;
            CSR_SOFTENING: softening_ff <= csr_wdata;
         endcase
      end
   end

   // offsets toward the source, as sign and magnitude
   assign dx_w  = {req_data.source_x[WORD_W-1], req_data.source_x}
                - {req_data.body_x[WORD_W-1], req_data.body_x};
   assign dy_w  = {req_data.source_y[WORD_W-1], req_data.source_y}
                - {req_data.body_y[WORD_W-1], req_data.body_y};
   assign adx_w = dx_w[OFS_W] ? (33'd0 - dx_w) : dx_w;
   assign ady_w = dy_w[OFS_W] ? (33'd0 - dy_w) : dy_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= sq_res.valid;
         e_vld_ff <= d_vld_ff;
         rsp_valid <= dv_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      a_adx_ff <= adx_w[OFS_W-1:0];
      a_ady_ff <= ady_w[OFS_W-1:0];
      a_sx_ff  <= dx_w[OFS_W];
      a_sy_ff  <= dy_w[OFS_W];
      a_gm1_ff <= gravity_ff * req_data.body_mass;
      a_ss_ff  <= softening_ff * softening_ff;
      a_m2_ff  <= req_data.source_mass;

      b_sqx_ff <= a_adx_ff * a_adx_ff;
      b_sqy_ff <= a_ady_ff * a_ady_ff;
      b_pl_ff  <= a_gm1_ff[31:0] * a_m2_ff;
      b_ph_ff  <= a_gm1_ff[63:32] * a_m2_ff;
      b_ss_ff  <= a_ss_ff;
      b_adx_ff <= a_adx_ff;
      b_ady_ff <= a_ady_ff;
      b_sx_ff  <= a_sx_ff;
      b_sy_ff  <= a_sy_ff;

      c_tag_ff <= c_tag_in;
   end

   always_comb begin
      c_tag_in.d2   = {2'b00, b_sqx_ff} + {2'b00, b_sqy_ff} + {2'b00, b_ss_ff};
      c_tag_in.prod = {b_ph_ff, 32'd0} + {32'd0, b_pl_ff};
      c_tag_in.adx  = b_adx_ff;
      c_tag_in.ady  = b_ady_ff;
      c_tag_in.sx   = b_sx_ff;
      c_tag_in.sy   = b_sy_ff;
   end

   sgf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_vld_ff),
      .in_tag   (c_tag_ff),
      .out_res  (sq_res)
   );

   // partial products of the divisor D2*R and of the numerators P*|d|
   always_ff @(posedge clock) begin
      d_dlo_ff <= sq_res.tag.d2[32:0] * sq_res.root;
      d_dhi_ff <= sq_res.tag.d2[65:33] * sq_res.root;
      for (int k = 0; k < 3; k++) begin
         d_nx_ff[k] <= sq_res.tag.prod[32*k +: 32] * sq_res.tag.adx;
         d_ny_ff[k] <= sq_res.tag.prod[32*k +: 32] * sq_res.tag.ady;
      end
      d_tag_ff.sx    <= sq_res.tag.sx;
      d_tag_ff.sy    <= sq_res.tag.sy;
      d_tag_ff.coinc <= (sq_res.tag.d2 == '0);

      e_den_ff <= {d_dhi_ff, 33'd0} + {33'd0, d_dlo_ff};
      e_nx_ff  <= {d_nx_ff[2], 64'd0} + {32'd0, d_nx_ff[1], 32'd0} + {64'd0, d_nx_ff[0]};
      e_ny_ff  <= {d_ny_ff[2], 64'd0} + {32'd0, d_ny_ff[1], 32'd0} + {64'd0, d_ny_ff[0]};
      e_tag_ff <= d_tag_ff;
   end

   sgf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (e_vld_ff),
      .in_den   (e_den_ff),
      .in_num_x (e_nx_ff),
      .in_num_y (e_ny_ff),
      .in_tag   (e_tag_ff),
      .out_res  (dv_res)
   );

   // saturate, apply sign, drop everything on a zero softened distance
   always_comb begin
      clip_x_w = dv_res.big_x || (dv_res.tag.sx ? (dv_res.quo_x[31] && (|dv_res.quo_x[30:0]))
                                                : dv_res.quo_x[31]);
      clip_y_w = dv_res.big_y || (dv_res.tag.sy ? (dv_res.quo_y[31] && (|dv_res.quo_y[30:0]))
                                                : dv_res.quo_y[31]);
      if (clip_x_w) begin
         rsp_in.force_x = dv_res.tag.sx ? NEG_LIMIT : POS_LIMIT;
      end else begin
         rsp_in.force_x = dv_res.tag.sx ? (32'd0 - dv_res.quo_x) : dv_res.quo_x;
      end
      if (clip_y_w) begin
         rsp_in.force_y = dv_res.tag.sy ? NEG_LIMIT : POS_LIMIT;
      end else begin
         rsp_in.force_y = dv_res.tag.sy ? (32'd0 - dv_res.quo_y) : dv_res.quo_y;
      end
      rsp_in.coincident = dv_res.tag.coinc;
      rsp_in.clipped    = clip_x_w || clip_y_w;
      if (dv_res.tag.coinc) begin
         rsp_in.force_x = '0;
         rsp_in.force_y = '0;
         rsp_in.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data <= rsp_in;
   end

`ifndef SYNTHESIS
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("response without a matching request");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("request lost in the pipeline");

   a_coinc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.coincident) |->
         (rsp_data.force_x == '0 && rsp_data.force_y == '0 && !rsp_data.clipped))
      else $error("coincident result carries a force");

   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clipped) |->
         (rsp_data.force_x == POS_LIMIT || rsp_data.force_x == NEG_LIMIT ||
          rsp_data.force_y == POS_LIMIT || rsp_data.force_y == NEG_LIMIT))
      else $error("clipped result not at a limit");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the softened 2D gravity force pipeline.
module tb;
   import sgf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRAVITY;
   logic [WORD_W-1:0]    csr_wdata = '0;

   logic [31:0] gravity_q = GRAVITY_RESET;
   logic [31:0] soft_q    = SOFTENING_RESET;

   rsp_type expected_forces[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      coincident_count = 0;
   int      clipped_count = 0;
   int      idle_cycles = 0;
   int      send_gap_pct = 0;

   softened_gravity_force_2d u_dut (.*);

   always #5 clock = ~clock;

   // one force component: sign(d) * floor(p*|d| / den), saturated
   function automatic logic [31:0] axis_force(input logic signed [32:0] d,
                                              input logic [95:0] p,
                                              input logic [98:0] den,
                                              inout logic clip);
      logic [32:0]  mag;
      logic [127:0] num;
      logic [127:0] quo;
      logic [31:0]  lim;
      if (d == 0) return 32'd0;
      mag = d[32] ? -d : d;
      num = p * mag;
      quo = num / den;
      lim = d[32] ? NEG_LIMIT : POS_LIMIT;
      if (quo > lim) begin
         clip = 1'b1;
         quo = lim;
      end
      return d[32] ? -quo[31:0] : quo[31:0];
   endfunction

   function automatic rsp_type gravity_force(input req_type r);
      logic signed [32:0] dx, dy;
      logic [32:0]  adx, ady;
      logic [65:0]  d2;
      logic [34:0]  root, trial;
      logic [95:0]  p;
      logic [98:0]  den;
      logic         clip;
      rsp_type      o;
      dx = $signed(r.source_x) - $signed(r.body_x);
      dy = $signed(r.source_y) - $signed(r.body_y);
      adx = dx[32] ? -dx : dx;
      ady = dy[32] ? -dy : dy;
      d2 = 66'(adx) * adx + 66'(ady) * ady + 66'(soft_q) * soft_q;
      o = '0;
      if (d2 == 0) begin
         o.coincident = 1'b1;
         return o;
      end
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (35'd1 << b);
         if (70'(trial) * trial <= 70'(d2)) root = trial;
      end
      den = 99'(d2) * root;
      p = 96'(gravity_q) * r.body_mass * r.source_mass;
      clip = 1'b0;
      o.force_x = axis_force(dx, p, den, clip);
      o.force_y = axis_force(dy, p, den, clip);
      o.clipped = clip;
      return o;
   endfunction

   // start stays high after the transaction so that the next one can follow directly
   task automatic send_pair(input req_type r);
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_forces.push_back(gravity_force(r));
      sent_count++;
      @(negedge clock);
   endtask

   // hold until the pipe has drained
   task automatic drain();
      start <= 1'b0;
      while (expected_forces.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] v);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GRAVITY) gravity_q = v;
      else soft_q = v;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(65536 * 8)) - 65536 * 4);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_pair(input bit wide_range);
      req_type r;
      if (wide_range) begin
         r.body_x = rand_word(); r.body_y = rand_word();
         r.source_x = rand_word(); r.source_y = rand_word();
         r.body_mass = $urandom; r.source_mass = $urandom;
      end else begin
         // nearby bodies with moderate masses
         r.body_x = 32'(int'($urandom_range(1 << 22)) - (1 << 21));
         r.body_y = 32'(int'($urandom_range(1 << 22)) - (1 << 21));
         r.source_x = r.body_x + 32'(int'($urandom_range(1 << 22)) - (1 << 21));
         r.source_y = r.body_y + 32'(int'($urandom_range(1 << 22)) - (1 << 21));
         r.body_mass = $urandom_range(1 << 20);
         r.source_mass = $urandom_range(1 << 20);
         if ($urandom_range(15) == 0) r.source_y = r.body_y;
      end
      return r;
   endfunction

   function automatic req_type make_pair(input logic [31:0] bx, by, bm, sx, sy, sm);
      req_type r;
      r.body_x = bx; r.body_y = by; r.body_mass = bm;
      r.source_x = sx; r.source_y = sy; r.source_mass = sm;
      return r;
   endfunction

   task automatic test_directed();
      send_pair(make_pair(0, 0, 32'h10000, 0, 0, 32'h10000));            // coincident
      send_pair(make_pair(5, -7, 32'hFFFF_FFFF, 5, -7, 32'hFFFF_FFFF));
      send_pair(make_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h10000));
      send_pair(make_pair(0, 0, 32'h10000, 0, -32'h10000, 32'h10000));
      send_pair(make_pair(0, 0, 32'h10000, 32'h30000, 32'h40000, 32'h20000));
      send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF));      // clipped
      send_pair(make_pair(1, 1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));      // negative clip
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h10000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h10000));
      send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_pair(make_pair(0, 0, 0, 32'h10000, 32'h10000, 32'h10000));      // zero mass
      send_pair(make_pair(0, 0, 32'h10000, 0, 1, 32'h10000));
      send_pair(make_pair(0, 0, 32'h10000, -1, 0, 32'h10000));
   endtask

   task automatic test_softening();
      write_csr(CSR_SOFTENING, 32'h10000);
      send_pair(make_pair(0, 0, 32'h10000, 0, 0, 32'h10000));
      send_pair(make_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
      write_csr(CSR_SOFTENING, 32'd1);
      send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF));
      write_csr(CSR_SOFTENING, 32'hFFFF_FFFF);
      send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF));
      write_csr(CSR_GRAVITY, 32'hFFFF_FFFF);
      send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      write_csr(CSR_GRAVITY, 32'd0);
      send_pair(make_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h10000));
   endtask

   task automatic test_random(input int count, input int gap_pct);
      send_gap_pct = gap_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 55 == 0) begin
            write_csr(CSR_GRAVITY, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 18));
            write_csr(CSR_SOFTENING, ($urandom_range(3) == 0) ? $urandom
                                                              : $urandom_range(1 << 17));
         end
         send_pair(rand_pair($urandom_range(3) == 0));
      end
      send_gap_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_forces.size() == 0) begin
            $error("unexpected result");
            error_count++;
         end else begin
            exp_r = expected_forces.pop_front();
            checked_count++;
            if (exp_r.coincident) coincident_count++;
            if (exp_r.clipped) clipped_count++;
            if (rsp_data.force_x !== exp_r.force_x) begin
               $error("force_x expected %h actual %h", exp_r.force_x, rsp_data.force_x);
               error_count++;
            end
            if (rsp_data.force_y !== exp_r.force_y) begin
               $error("force_y expected %h actual %h", exp_r.force_y, rsp_data.force_y);
               error_count++;
            end
            if (rsp_data.coincident !== exp_r.coincident) begin
               $error("coincident expected %b actual %b", exp_r.coincident,
                      rsp_data.coincident);
               error_count++;
            end
            if (rsp_data.clipped !== exp_r.clipped) begin
               $error("clipped expected %b actual %b", exp_r.clipped, rsp_data.clipped);
               error_count++;
            end
         end
      end
   end

   // count cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_softening();
      write_csr(CSR_GRAVITY, GRAVITY_RESET);
      write_csr(CSR_SOFTENING, SOFTENING_RESET);
      test_random(220, 16);
      test_random(210, 87);
      test_random(220, 0);
      drain();
      if (expected_forces.size() != 0) begin
         $error("%0d results never arrived", expected_forces.size());
         error_count++;
      end
      $display("covered %0d pairs, %0d checked: %0d coincident, %0d clipped",
               sent_count, checked_count, coincident_count, clipped_count);
      $display("register extremes and random settings of G and softening exercised");
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
